@@ rtl/core/cwit_pkg.sv @@
// Package: types and constants shared by the contour winding test block.
`timescale 1ns / 1ps
package cwit_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_QUERY_X   = 2'd0;
  localparam logic [1:0] REG_QUERY_Y   = 2'd1;
  localparam logic [1:0] REG_QUERY_Z   = 2'd2;
  localparam logic [1:0] REG_THRESHOLD = 2'd3;

  localparam logic [31:0] THRESHOLD_RESET = 32'd589824;  // 9.0 in Q16.16
  localparam int unsigned ACC_W   = 48;                  // Q23.24 accumulator
  localparam int unsigned FRAC_SH = 24;

  // One contour segment as it arrives
  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic               last_segment;
  } in_item_t;

  // One contour result
  typedef struct packed {
    logic        inside_res;
    logic [31:0] angle_squared;
    logic        degenerate;
  } out_item_t;

  // Classified segment: offset to start, direction, flags
  typedef struct packed {
    logic [32:0] rx;
    logic [32:0] ry;
    logic [32:0] rz;
    logic [32:0] dx;
    logic [32:0] dy;
    logic [32:0] dz;
    logic        last;
    logic        degen;
  } seg_t;

endpackage

@@ rtl/core/contour_winding_inside_test_top.sv @@
// Top level: configuration registers and the front, queue and back of the winding test.
`timescale 1ns / 1ps
// Contour winding test. Segments of one closed contour arrive one per item; the
// block adds (r x d)/|r|^2 for each to a saturating Q23.24 vector and, on the
// segment marked last, returns the squared magnitude and the inside flag. A
// segment that starts on the query point adds nothing to the vector. Any
// other segment needs 9 products on the one 33x33 multiplier, then 3 quotients
// from the serial divider at one bit per cycle, which sets the rate. The last
// segment also squares the three components for the magnitude. A two-entry
// queue lets up to two segments wait while one is worked on. Write the query point
// and threshold only while the block is idle.
module contour_winding_inside_test_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cwit_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cwit_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import cwit_pkg::*;

  logic [31:0] query_x_q, query_y_q, query_z_q, threshold_q;
  logic        push, full, pop, empty;
  seg_t        seg_in, seg_out;

  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_x_q   <= '0;
      query_y_q   <= '0;
      query_z_q   <= '0;
      threshold_q <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_QUERY_X:   query_x_q   <= pwdata;
        REG_QUERY_Y:   query_y_q   <= pwdata;
        REG_QUERY_Z:   query_z_q   <= pwdata;
        REG_THRESHOLD: threshold_q <= pwdata;
        default:       ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[3:2])
      REG_QUERY_X:   prdata = query_x_q;
      REG_QUERY_Y:   prdata = query_y_q;
      REG_QUERY_Z:   prdata = query_z_q;
      REG_THRESHOLD: prdata = threshold_q;
      default:       prdata = '0;
    endcase
  end

  cwit_front u_front (
    .item_i    (in_data_i),
    .valid_i   (in_valid_i),
    .stall_o   (in_stall_o),
    .query_x_i (query_x_q),
    .query_y_i (query_y_q),
    .query_z_i (query_z_q),
    .push_o    (push),
    .full_i    (full),
    .seg_o     (seg_in)
  );

  cwit_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (seg_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (seg_out),
    .empty_o (empty)
  );

  cwit_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seg_i       (seg_out),
    .empty_i     (empty),
    .pop_o       (pop),
    .threshold_i (threshold_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/core/cwit_front.sv @@
// Front end: takes segments, forms offset and direction, flags a start on the query point.
`timescale 1ns / 1ps
module cwit_front (
  input  cwit_pkg::in_item_t  item_i,
  input  logic                valid_i,
  output logic                stall_o,
  input  logic [31:0]         query_x_i,
  input  logic [31:0]         query_y_i,
  input  logic [31:0]         query_z_i,
  output logic                push_o,
  input  logic                full_i,
  output cwit_pkg::seg_t      seg_o
);
  import cwit_pkg::*;

  logic signed [32:0] rx, ry, rz;

  // Offset of the segment start from the query point
  assign rx = {item_i.start_x[31], item_i.start_x} - {query_x_i[31], query_x_i};
  assign ry = {item_i.start_y[31], item_i.start_y} - {query_y_i[31], query_y_i};
  assign rz = {item_i.start_z[31], item_i.start_z} - {query_z_i[31], query_z_i};

  // Build the classified segment
  always_comb begin
    seg_o.rx    = rx;
    seg_o.ry    = ry;
    seg_o.rz    = rz;
    seg_o.dx    = {item_i.end_x[31], item_i.end_x} - {item_i.start_x[31], item_i.start_x};
    seg_o.dy    = {item_i.end_y[31], item_i.end_y} - {item_i.start_y[31], item_i.start_y};
    seg_o.dz    = {item_i.end_z[31], item_i.end_z} - {item_i.start_z[31], item_i.start_z};
    seg_o.last  = item_i.last_segment;
    seg_o.degen = (rx == '0) && (ry == '0) && (rz == '0);
  end

  // Hold the item while the queue is full
  assign stall_o = full_i;
  assign push_o  = valid_i && !full_i;

endmodule

@@ rtl/core/cwit_queue.sv @@
// Two-entry queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps
module cwit_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cwit_pkg::seg_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output cwit_pkg::seg_t data_o,
  output logic           empty_o
);
  import cwit_pkg::*;

  seg_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i)      count_q <= count_q + 2'd1;
      else if (pop_i && !push_i) count_q <= count_q - 2'd1;
    end
  end

endmodule

@@ rtl/core/cwit_back.sv @@
// Back end: shared multiplier, serial divider, saturating accumulator and result register.
`timescale 1ns / 1ps
module cwit_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cwit_pkg::seg_t      seg_i,
  input  logic                empty_i,
  output logic                pop_o,
  input  logic [31:0]         threshold_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cwit_pkg::out_item_t out_data_o
);
  import cwit_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_MWAIT, ST_DINIT, ST_DIV, ST_ACC, ST_SQ, ST_SWAIT, ST_FIN
  } state_e;

  typedef enum logic [1:0] { P_RSQ, P_CSET, P_CSUB, P_SQ } ptag_e;

  localparam int unsigned NUM_W = 67 + FRAC_SH;  // dividend bits
  localparam logic [48:0] LIM_POS = 49'h0_7FFF_FFFF_FFFF;
  localparam logic [48:0] LIM_NEG = 49'h0_8000_0000_0000;
  localparam logic signed [49:0] ACC_MAX = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] ACC_MIN = -50'sh0_8000_0000_0000;

  state_e state_q;
  seg_t   seg_q;
  logic [3:0]  k_q;
  logic [1:0]  j_q, term_q;
  logic [66:0] rsq_q;
  logic signed [66:0] cross_q [3];
  logic signed [ACC_W-1:0] acc_q [3];
  logic        deg_q;
  // product pipeline
  logic        pv_q;
  ptag_e       ptag_q;
  logic [1:0]  pidx_q, psh_q;
  logic signed [65:0] prod_q;
  // divider
  logic [NUM_W-1:0] num_q;
  logic [66:0] rem_q;
  logic [47:0] quo_q;
  logic        ovf_q, neg_q;
  logic [6:0]  cnt_q;
  // final sum of squares
  logic [97:0] sum_q;
  logic        out_valid_q;
  out_item_t   out_q;

  logic signed [32:0] op_a, op_b;
  logic signed [65:0] prod_d;
  ptag_e       ptag_d;
  logic [1:0]  pidx_d;
  logic signed [ACC_W-1:0] acc_sel;
  logic [ACC_W-1:0] acc_mag;
  logic signed [66:0] cross_sel;
  logic [66:0] cross_mag;
  logic [67:0] rem_sh;
  logic        ge;
  logic [48:0] lim, qm;
  logic signed [49:0] ratio, acc_sum;
  logic signed [ACC_W-1:0] acc_new;
  logic [97:0] sq_term;
  logic [31:0] sq;

  // Operand selection for the shared multiplier
  always_comb begin
    acc_sel = acc_q[j_q];
    acc_mag = acc_sel[ACC_W-1] ? ACC_W'(-acc_sel) : ACC_W'(acc_sel);
    op_a    = '0;
    op_b    = '0;
    ptag_d  = P_SQ;
    pidx_d  = 2'd0;
    if (state_q == ST_MUL) begin
      unique case (k_q)
        4'd0: begin op_a = seg_q.rx; op_b = seg_q.rx; ptag_d = P_RSQ; end
        4'd1: begin op_a = seg_q.ry; op_b = seg_q.ry; ptag_d = P_RSQ; end
        4'd2: begin op_a = seg_q.rz; op_b = seg_q.rz; ptag_d = P_RSQ; end
        4'd3: begin op_a = seg_q.ry; op_b = seg_q.dz; ptag_d = P_CSET; pidx_d = 2'd0; end
        4'd4: begin op_a = seg_q.rz; op_b = seg_q.dy; ptag_d = P_CSUB; pidx_d = 2'd0; end
        4'd5: begin op_a = seg_q.rz; op_b = seg_q.dx; ptag_d = P_CSET; pidx_d = 2'd1; end
        4'd6: begin op_a = seg_q.rx; op_b = seg_q.dz; ptag_d = P_CSUB; pidx_d = 2'd1; end
        4'd7: begin op_a = seg_q.rx; op_b = seg_q.dy; ptag_d = P_CSET; pidx_d = 2'd2; end
        4'd8: begin op_a = seg_q.ry; op_b = seg_q.dx; ptag_d = P_CSUB; pidx_d = 2'd2; end
        default: begin op_a = '0; op_b = '0; ptag_d = P_RSQ; end
      endcase
    end else begin
      // magnitude split in high and low halves
      case (term_q)
        2'd0:    begin op_a = {9'd0, acc_mag[47:24]}; op_b = {9'd0, acc_mag[47:24]}; end
        2'd1:    begin op_a = {9'd0, acc_mag[47:24]}; op_b = {9'd0, acc_mag[23:0]};  end
        default: begin op_a = {9'd0, acc_mag[23:0]};  op_b = {9'd0, acc_mag[23:0]};  end
      endcase
    end
  end

  assign prod_d = op_a * op_b;

  // Scale a square term into the sum
  always_comb begin
    case (psh_q)
      2'd0:    sq_term = {32'd0, prod_q} << 48;
      2'd1:    sq_term = {32'd0, prod_q} << 25;
      default: sq_term = {32'd0, prod_q};
    endcase
  end

  // Divider step and ratio saturation
  always_comb begin
    cross_sel = cross_q[j_q];
    cross_mag = cross_sel[66] ? 67'(-cross_sel) : 67'(cross_sel);
    rem_sh    = {rem_q, num_q[NUM_W-1]};
    ge        = rem_sh >= {1'b0, rsq_q};
    lim       = neg_q ? LIM_NEG : LIM_POS;
    qm        = (ovf_q || ({1'b0, quo_q} > lim)) ? lim : {1'b0, quo_q};
    ratio     = neg_q ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
    acc_sum   = 50'(acc_sel) + ratio;
    if (acc_sum > ACC_MAX)      acc_new = ACC_MAX[ACC_W-1:0];
    else if (acc_sum < ACC_MIN) acc_new = ACC_MIN[ACC_W-1:0];
    else                        acc_new = acc_sum[ACC_W-1:0];
    sq = (sum_q[97:64] != '0) ? 32'hFFFF_FFFF : sum_q[63:32];
  end

  assign pop_o       = (state_q == ST_IDLE) && !empty_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Sequencer with its datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      j_q         <= '0;
      term_q      <= '0;
      deg_q       <= 1'b0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q[0]    <= '0;
      acc_q[1]    <= '0;
      acc_q[2]    <= '0;
      rsq_q       <= '0;
      sum_q       <= '0;
      seg_q       <= '0;
      cross_q[0]  <= '0;
      cross_q[1]  <= '0;
      cross_q[2]  <= '0;
      ptag_q      <= P_RSQ;
      pidx_q      <= '0;
      psh_q       <= '0;
      prod_q      <= '0;
      num_q       <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      ovf_q       <= 1'b0;
      neg_q       <= 1'b0;
      cnt_q       <= '0;
      out_q       <= '0;
    end else begin
      // drop the result once taken
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;

      // retire the product issued last cycle
      pv_q   <= (state_q == ST_MUL) || (state_q == ST_SQ);
      prod_q <= prod_d;
      ptag_q <= (state_q == ST_MUL) ? ptag_d : P_SQ;
      pidx_q <= pidx_d;
      psh_q  <= term_q;
      if (pv_q) begin
        case (ptag_q)
          P_RSQ:   rsq_q <= rsq_q + {1'b0, prod_q};
          P_CSET:  cross_q[pidx_q] <= {prod_q[65], prod_q};
          P_CSUB:  cross_q[pidx_q] <= cross_q[pidx_q] - {prod_q[65], prod_q};
          default: sum_q <= sum_q + sq_term;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            seg_q <= seg_i;
            if (seg_i.degen) begin
              deg_q <= 1'b1;
              if (seg_i.last) begin
                sum_q   <= '0;
                j_q     <= '0;
                term_q  <= '0;
                state_q <= ST_SQ;
              end
            end else begin
              rsq_q   <= '0;
              k_q     <= '0;
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          k_q <= k_q + 4'd1;
          if (k_q == 4'd8) state_q <= ST_MWAIT;
        end
        ST_MWAIT: begin
          j_q     <= '0;
          state_q <= ST_DINIT;
        end
        ST_DINIT: begin
          neg_q   <= cross_sel[66];
          num_q   <= {cross_mag, {FRAC_SH{1'b0}}};
          rem_q   <= '0;
          quo_q   <= '0;
          ovf_q   <= 1'b0;
          cnt_q   <= 7'(NUM_W - 1);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          // one quotient bit per cycle
          rem_q <= ge ? 67'(rem_sh - {1'b0, rsq_q}) : rem_sh[66:0];
          num_q <= num_q << 1;
          quo_q <= {quo_q[46:0], ge};
          if (ge && (cnt_q >= 7'd48)) ovf_q <= 1'b1;
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == '0) state_q <= ST_ACC;
        end
        ST_ACC: begin
          acc_q[j_q] <= acc_new;
          if (j_q == 2'd2) begin
            j_q <= '0;
            if (seg_q.last) begin
              sum_q   <= '0;
              term_q  <= '0;
              state_q <= ST_SQ;
            end else begin
              state_q <= ST_IDLE;
            end
          end else begin
            j_q     <= j_q + 2'd1;
            state_q <= ST_DINIT;
          end
        end
        ST_SQ: begin
          if (term_q == 2'd2) begin
            term_q <= '0;
            if (j_q == 2'd2) state_q <= ST_SWAIT;
            else             j_q <= j_q + 2'd1;
          end else begin
            term_q <= term_q + 2'd1;
          end
        end
        ST_SWAIT: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q         <= 1'b1;
            out_q.inside_res    <= sq > threshold_i;
            out_q.angle_squared <= sq;
            out_q.degenerate    <= deg_q;
            acc_q[0]            <= '0;
            acc_q[1]            <= '0;
            acc_q[2]            <= '0;
            deg_q               <= 1'b0;
            j_q                 <= '0;
            state_q             <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/cwit_checker.sv @@
// Port checker for the contour winding test and its bind.
`timescale 1ns / 1ps
module cwit_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input cwit_pkg::out_item_t out_data_o,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [3:0]          paddr,
  input logic [31:0]         pwdata,
  input logic [31:0]         prdata
);
  import cwit_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Inside never reported for a zero magnitude
  a_inside_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.inside_res |-> out_data_o.angle_squared != '0)
    else $error("inside flagged with zero magnitude");

  // A register reads back what was just written
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(psel && penable && pwrite) && !pwrite && paddr == $past(paddr)
      |-> prdata == $past(pwdata))
    else $error("register readback mismatch");

endmodule

bind contour_winding_inside_test_top cwit_checker u_cwit_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata)
);

@@ dv/tb_top.sv @@
// Testbench for the contour winding test block: directed table, random contours, self-check.
`timescale 1ns / 1ps
module tb_top;
  import cwit_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned DRAIN_WAIT  = 400;
  localparam int unsigned RAND_ITEMS  = 1100;
  localparam int unsigned N_PHASES    = 6;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  contour_winding_inside_test_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state: query point, threshold and the winding accumulator
  logic signed [31:0] qx, qy, qz;
  logic [31:0]        thresh;
  longint             wind_acc [3];
  bit                 degen_seen;

  out_item_t   contour_results [$];
  int unsigned mismatches;
  int unsigned cycles;
  bit          stim_done;

  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -64'sh0000_7FFF_FFFF_FFFF - 1;

  // Directed table row
  typedef struct {
    in_item_t  seg;
    bit        typed;
    out_item_t res;
  } row_t;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, contour_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Quotient of one cross component by |r|^2, saturated to Q23.24
  function automatic longint winding_ratio(logic signed [127:0] cr, logic [127:0] rsq);
    logic [127:0] mag;
    logic [127:0] quo;
    logic [127:0] lim;
    bit           neg;
    neg = cr[127];
    mag = neg ? 128'(-cr) : 128'(cr);
    quo = (mag << FRAC_SH) / rsq;
    lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
    if (quo > lim) quo = lim;
    return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
  endfunction

  function automatic longint sat_accum(longint a, longint b);
    longint s;
    s = a + b;
    if (s > ACC_HI) return ACC_HI;
    if (s < ACC_LO) return ACC_LO;
    return s;
  endfunction

  // Advance the winding state by one segment; return 1 with the result on a last segment
  function automatic bit winding_step(in_item_t s, output out_item_t res);
    logic signed [127:0] r [3];
    logic signed [127:0] d [3];
    logic signed [127:0] cr [3];
    logic [127:0]        rsq;
    logic [127:0]        sum;
    logic [127:0]        m;
    logic [127:0]        sq;
    r[0] = 128'(s.start_x) - 128'(qx);
    r[1] = 128'(s.start_y) - 128'(qy);
    r[2] = 128'(s.start_z) - 128'(qz);
    d[0] = 128'(s.end_x) - 128'(s.start_x);
    d[1] = 128'(s.end_y) - 128'(s.start_y);
    d[2] = 128'(s.end_z) - 128'(s.start_z);
    rsq = r[0] * r[0] + r[1] * r[1] + r[2] * r[2];
    res = '0;
    if (rsq == 0) begin
      degen_seen = 1'b1;
    end else begin
      cr[0] = r[1] * d[2] - r[2] * d[1];
      cr[1] = r[2] * d[0] - r[0] * d[2];
      cr[2] = r[0] * d[1] - r[1] * d[0];
      for (int i = 0; i < 3; i++)
        wind_acc[i] = sat_accum(wind_acc[i], winding_ratio(cr[i], rsq));
    end
    if (!s.last_segment) return 0;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      m = (wind_acc[i] < 0) ? 128'(-wind_acc[i]) : 128'(wind_acc[i]);
      sum = sum + m * m;
    end
    sq = sum >> 32;
    if (sq > 128'hFFFF_FFFF) sq = 128'hFFFF_FFFF;
    res.angle_squared = sq[31:0];
    res.inside_res    = (sq[31:0] > thresh);
    res.degenerate    = degen_seen;
    for (int i = 0; i < 3; i++) wind_acc[i] = 0;
    degen_seen = 1'b0;
    return 1;
  endfunction

  // Write one register over the configuration port and mirror it
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_QUERY_X:   qx = val;
      REG_QUERY_Y:   qy = val;
      REG_QUERY_Z:   qz = val;
      REG_THRESHOLD: thresh = val;
      default: ;
    endcase
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // Wait for every expected result, then let the back end settle
  task automatic drain();
    while (contour_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Random gap length: mostly none or short, a few long
  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(80, 10);
  endfunction

  // Send one segment, hold it until accepted, queue the expected result
  task automatic send_segment(in_item_t s, bit typed, out_item_t typed_res);
    out_item_t res;
    bit        has;
    in_data_i  = s;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    has = winding_step(s, res);
    if (has) contour_results.push_back(typed ? typed_res : res);
    @(negedge clk_i);
    if (gap_len() != 0) begin
      in_valid_i = 1'b0;
      repeat (gap_len()) @(negedge clk_i);
    end
  endtask

  // Result check
  initial begin
    out_item_t want;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (contour_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data_o);
        end else begin
          want = contour_results.pop_front();
          if (out_data_o.inside_res !== want.inside_res ||
              out_data_o.angle_squared !== want.angle_squared ||
              out_data_o.degenerate !== want.degenerate) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: exp in=%0b sq=%h dg=%0b got in=%0b sq=%h dg=%0b",
                       want.inside_res, want.angle_squared, want.degenerate,
                       out_data_o.inside_res, out_data_o.angle_squared,
                       out_data_o.degenerate);
          end
        end
      end
      @(negedge clk_i);
      out_stall_i = (gap_len() != 0);
    end
  end

  function automatic in_item_t make_seg(int sx, int sy, int sz, int ex, int ey, int ez, bit l);
    in_item_t s;
    s.start_x = sx; s.start_y = sy; s.start_z = sz;
    s.end_x = ex; s.end_y = ey; s.end_z = ez;
    s.last_segment = l;
    return s;
  endfunction

  // Coordinate near the query, far off, or anywhere
  function automatic logic [31:0] pick_coord(logic [31:0] q);
    int unsigned p;
    p = $urandom_range(9);
    if (p < 6) return q + 32'($signed($urandom_range(1 << 19)) - (1 << 18));
    if (p < 9) return $urandom;
    return ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
  endfunction

  // One random contour: chained and closed mostly, broken sometimes
  task automatic send_contour(output int unsigned n);
    logic [31:0] px [10];
    logic [31:0] py [10];
    logic [31:0] pz [10];
    int unsigned len;
    bit          broken;
    in_item_t    s;
    len = $urandom_range(9) < 7 ? $urandom_range(6, 3) : $urandom_range(9, 1);
    broken = ($urandom_range(9) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) begin
        px[i] = qx; py[i] = qy; pz[i] = qz;
      end else begin
        px[i] = pick_coord(qx); py[i] = pick_coord(qy); pz[i] = pick_coord(qz);
      end
    end
    for (int i = 0; i < len; i++) begin
      s.start_x = px[i]; s.start_y = py[i]; s.start_z = pz[i];
      s.end_x = px[(i + 1) % len]; s.end_y = py[(i + 1) % len]; s.end_z = pz[(i + 1) % len];
      if (broken) begin
        s.end_x = $urandom; s.end_y = $urandom; s.end_z = $urandom;
      end
      s.last_segment = (i == len - 1);
      send_segment(s, 1'b0, '0);
    end
    n = len;
  endtask

  localparam int ONE  = 32'sh0001_0000;
  localparam int PMAX = 32'sh7FFF_FFFF;
  localparam int PMIN = -32'sh7FFF_FFFF - 1;

  // Stimulus
  initial begin
    row_t        rows [$];
    row_t        rw;
    int unsigned sent;
    int unsigned n;
    logic [31:0] ph_q [N_PHASES][4];

    rst_ni = 1'b0;
    in_valid_i = 1'b0; in_data_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cycles = 0; mismatches = 0; stim_done = 1'b0;
    qx = 0; qy = 0; qz = 0; thresh = THRESHOLD_RESET;
    for (int i = 0; i < 3; i++) wind_acc[i] = 0;
    degen_seen = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (4) @(negedge clk_i);

    // Directed table; reset registers apply at first
    rw.typed = 1'b1;
    rw.seg = make_seg(0, 0, 0, ONE, ONE, ONE, 1'b1);      // start on query: nothing added
    rw.res = '{inside_res: 1'b0, angle_squared: 32'd0, degenerate: 1'b1};
    rows.push_back(rw);
    rw.seg = make_seg(0, 0, 0, PMAX, PMIN, PMAX, 1'b0);  // two degenerate segments
    rows.push_back(rw);
    rw.seg = make_seg(0, 0, 0, PMIN, PMAX, PMIN, 1'b1);
    rows.push_back(rw);
    rw.typed = 1'b0;
    rw.res = '0;
    rw.seg = make_seg(ONE, 0, 0, ONE, ONE, 0, 1'b1);
    rows.push_back(rw);
    rw.seg = make_seg(PMAX, PMAX, PMAX, PMIN, PMIN, PMIN, 1'b0);
    rows.push_back(rw);
    rw.seg = make_seg(PMIN, PMIN, PMIN, PMAX, PMAX, PMAX, 1'b1);
    rows.push_back(rw);
    rw.seg = make_seg(1, 0, 0, PMIN, PMAX, PMIN, 1'b1);   // tiny r, huge d: saturate
    rows.push_back(rw);
    rw.seg = make_seg(0, 1, 0, PMAX, 0, PMAX, 1'b0);
    rows.push_back(rw);
    rw.seg = make_seg(0, 0, -1, PMAX, PMIN, 0, 1'b1);
    rows.push_back(rw);
    // Unit square around the query: winding sum of 4.0, inside
    rw.seg = make_seg(ONE, ONE, 0, -ONE, ONE, 0, 1'b0);
    rows.push_back(rw);
    rw.seg = make_seg(-ONE, ONE, 0, -ONE, -ONE, 0, 1'b0);
    rows.push_back(rw);
    rw.seg = make_seg(-ONE, -ONE, 0, ONE, -ONE, 0, 1'b0);
    rows.push_back(rw);
    rw.seg = make_seg(ONE, -ONE, 0, ONE, ONE, 0, 1'b1);
    rows.push_back(rw);
    // Degenerate segment inside a normal contour
    rw.seg = make_seg(0, 0, 0, ONE, 0, ONE, 1'b0);
    rows.push_back(rw);
    rw.seg = make_seg(ONE, 0, ONE, 0, ONE, 0, 1'b1);
    rows.push_back(rw);
    // Triangle away from the query: outside
    rw.seg = make_seg(8 * ONE, 0, 0, 9 * ONE, 0, 0, 1'b0);
    rows.push_back(rw);
    rw.seg = make_seg(9 * ONE, 0, 0, 9 * ONE, ONE, 0, 1'b0);
    rows.push_back(rw);
    rw.seg = make_seg(9 * ONE, ONE, 0, 8 * ONE, 0, 0, 1'b1);
    rows.push_back(rw);
    foreach (rows[i]) send_segment(rows[i].seg, rows[i].typed, rows[i].res);

    // Register settings per phase, extremes included
    ph_q[0] = '{32'd0, 32'd0, 32'd0, 32'd0};
    ph_q[1] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
    ph_q[2] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, THRESHOLD_RESET};
    ph_q[3] = '{$urandom, $urandom, $urandom, $urandom};
    ph_q[4] = '{32'h0001_8000, 32'hFFFE_0000, 32'h0000_4000, 32'h0001_0000};
    ph_q[5] = '{$urandom, $urandom, $urandom, $urandom_range(32'h0010_0000)};

    // Random contours, phase by phase; registers change only while idle
    sent = 0;
    for (int p = 0; p < N_PHASES; p++) begin
      in_valid_i = 1'b0;
      drain();
      reg_write(REG_QUERY_X, ph_q[p][0]);
      reg_write(REG_QUERY_Y, ph_q[p][1]);
      reg_write(REG_QUERY_Z, ph_q[p][2]);
      reg_write(REG_THRESHOLD, ph_q[p][3]);
      while (sent < (p + 1) * RAND_ITEMS / N_PHASES) begin
        send_contour(n);
        sent += n;
      end
    end
    in_valid_i = 1'b0;
    stim_done = 1'b1;
  end

  // End of run
  initial begin
    wait (stim_done);
    drain();
    if (mismatches == 0 && contour_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("mismatches: %0d", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/cwit_pkg.sv
rtl/core/cwit_front.sv
rtl/core/cwit_queue.sv
rtl/core/cwit_back.sv
rtl/core/contour_winding_inside_test_top.sv
rtl/core/cwit_checker.sv
dv/tb_top.sv
